FILE: src/v3alu_pkg.sv
// shared types, constants and rounding helpers for the vector arithmetic unit
// no dependencies; every other file refers to this package by scoped names
package v3alu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QW        = 32;          // width of one fixed-point value
   localparam int PW        = 2 * QW;      // full product width
   localparam int SW        = PW + 4;      // width for sums of products
   localparam int LANES     = 4;
   localparam int NSQ       = PW / 2;      // square root steps, one result bit each
   localparam int NDIV      = QW;          // divider steps, one quotient bit each

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] wide_type;
   typedef logic        [PW-1:0] uword_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_SCALE,
      OP_DIVIDE,
      OP_DOT,
      OP_CROSS,
      OP_MAG,
      OP_NORM
   } op_type;

   localparam q_type    Q_MAX  = {1'b0, {(QW - 1){1'b1}}};
   localparam q_type    Q_MIN  = {1'b1, {(QW - 1){1'b0}}};
   localparam q_type    ONE_Q  = q_type'(1) <<< FRAC_BITS;
   localparam wide_type HALF_W = wide_type'(1) <<< (FRAC_BITS - 1);

   typedef struct packed {
      op_type action;
      q_type  ax;
      q_type  ay;
      q_type  az;
      q_type  aw;
      q_type  bx;
      q_type  by;
      q_type  bz;
      q_type  bw;
      q_type  scalar;
   } req_type;

   typedef struct packed {
      q_type rx;
      q_type ry;
      q_type rz;
      q_type rw;
      q_type scalar_out;
      logic  div_zero;
   } rsp_type;

   // what travels down the pipe with every request
   typedef struct packed {
      logic                   valid;
      op_type                 action;
      q_type [LANES-1:0]      a;
      q_type                  s;
      q_type [LANES-1:0]      r;
      q_type                  sc;
      logic                   dz;
   } cmn_type;

   typedef struct packed {
      uword_type       rem;
      logic [QW-1:0]   d;
      logic [QW-1:0]   q;
      logic            neg;
      logic            ovf;
   } lane_type;

   function automatic q_type sat_q(input wide_type v);
      if (&v[SW-1:QW-1] || ~|v[SW-1:QW-1]) begin
         return v[QW-1:0];
      end else if (v[SW-1]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

   // round to nearest, ties toward plus infinity, then saturate
   function automatic q_type round_q(input wide_type v);
      wide_type t;
      t = v + HALF_W;
      t = t >>> FRAC_BITS;
      return sat_q(t);
   endfunction

endpackage

FILE: src/v3alu_if.sv
// valid/ready channel interfaces for requests and results
// depends on v3alu_pkg for the payload types
interface v3alu_req_if;
   logic                valid;
   logic                ready;
   v3alu_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface v3alu_rsp_if;
   logic                valid;
   logic                ready;
   v3alu_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/v3alu_front.sv
// first two pipeline stages: operand select and products, then sums and rounding
// depends on v3alu_pkg
module v3alu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  v3alu_pkg::req_type    in_data,
   output v3alu_pkg::cmn_type    out_cmn,
   output v3alu_pkg::uword_type  out_sq
);
   localparam int QW    = v3alu_pkg::QW;
   localparam int LANES = v3alu_pkg::LANES;

   v3alu_pkg::q_type    [LANES-1:0] a;
   v3alu_pkg::q_type    [LANES-1:0] b;
   v3alu_pkg::q_type                ma [6];
   v3alu_pkg::q_type                mb [6];
   v3alu_pkg::prod_type             prod_in [6];
   v3alu_pkg::prod_type             prod_ff [6];
   logic signed         [QW:0]      as_sum;
   v3alu_pkg::cmn_type              s1_in;
   v3alu_pkg::cmn_type              s1_ff;

   v3alu_pkg::wide_type             pw [6];
   v3alu_pkg::wide_type             w [LANES];
   v3alu_pkg::q_type                rq [LANES];
   v3alu_pkg::cmn_type              s2_in;
   v3alu_pkg::cmn_type              s2_ff;
   v3alu_pkg::uword_type            sq_in;
   v3alu_pkg::uword_type            sq_ff;

   assign a = {in_data.aw, in_data.az, in_data.ay, in_data.ax};
   assign b = {in_data.bw, in_data.bz, in_data.by, in_data.bx};

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         ma[j] = '0;
         mb[j] = '0;
      end
      unique case (in_data.action)
         v3alu_pkg::OP_SCALE: begin
            for (int j = 0; j < LANES; j++) begin
               ma[j] = a[j];
               mb[j] = in_data.scalar;
            end
         end
         v3alu_pkg::OP_DOT: begin
            for (int j = 0; j < 3; j++) begin
               ma[j] = a[j];
               mb[j] = b[j];
            end
         end
         v3alu_pkg::OP_CROSS: begin
            ma[0] = a[1]; mb[0] = b[2];
            ma[1] = b[1]; mb[1] = a[2];
            ma[2] = a[2]; mb[2] = b[0];
            ma[3] = b[2]; mb[3] = a[0];
            ma[4] = a[0]; mb[4] = b[1];
            ma[5] = b[0]; mb[5] = a[1];
         end
         v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
            for (int j = 0; j < 3; j++) begin
               ma[j] = a[j];
               mb[j] = a[j];
            end
         end
         default: ;
      endcase
      for (int j = 0; j < 6; j++) begin
         prod_in[j] = v3alu_pkg::prod_type'(ma[j]) * v3alu_pkg::prod_type'(mb[j]);
      end

      s1_in        = '0;
      s1_in.valid  = in_valid;
      s1_in.action = in_data.action;
      s1_in.a      = a;
      s1_in.s      = in_data.scalar;
      as_sum       = '0;
      for (int i = 0; i < LANES; i++) begin
         if (in_data.action == v3alu_pkg::OP_SUB) begin
            as_sum = {a[i][QW-1], a[i]} - {b[i][QW-1], b[i]};
         end else begin
            as_sum = {a[i][QW-1], a[i]} + {b[i][QW-1], b[i]};
         end
         if (in_data.action == v3alu_pkg::OP_ADD || in_data.action == v3alu_pkg::OP_SUB) begin
            s1_in.r[i] = v3alu_pkg::sat_q(v3alu_pkg::wide_type'(as_sum));
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         pw[k] = v3alu_pkg::wide_type'(prod_ff[k]);
      end
      for (int i = 0; i < LANES; i++) begin
         w[i] = '0;
      end
      unique case (s1_ff.action)
         v3alu_pkg::OP_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               w[i] = pw[i];
            end
         end
         v3alu_pkg::OP_CROSS: begin
            w[0] = pw[0] - pw[1];
            w[1] = pw[2] - pw[3];
            w[2] = pw[4] - pw[5];
         end
         v3alu_pkg::OP_DOT: w[0] = pw[0] + pw[1] + pw[2];
         default: ;
      endcase
      for (int i = 0; i < LANES; i++) begin
         rq[i] = v3alu_pkg::round_q(w[i]);
      end

      s2_in = s1_ff;
      unique case (s1_ff.action)
         v3alu_pkg::OP_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               s2_in.r[i] = rq[i];
            end
         end
         v3alu_pkg::OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               s2_in.r[i] = rq[i];
            end
            s2_in.r[3] = v3alu_pkg::ONE_Q;
         end
         v3alu_pkg::OP_DOT: s2_in.sc = rq[0];
         default: ;
      endcase

      // sum of squares wraps at 64 bits
      sq_in = v3alu_pkg::uword_type'(prod_ff[0]) + v3alu_pkg::uword_type'(prod_ff[1])
            + v3alu_pkg::uword_type'(prod_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
         for (int j = 0; j < 6; j++) begin
            prod_ff[j] <= prod_in[j];
         end
         s2_ff <= s2_in;
         sq_ff <= sq_in;
      end
   end

   assign out_cmn = s2_ff;
   assign out_sq  = sq_ff;

endmodule

FILE: src/v3alu_sqrt.sv
// pipelined integer square root, one result bit per stage, rounded to nearest
// depends on v3alu_pkg; sets the magnitude for magnitude and normalize requests
module v3alu_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  v3alu_pkg::cmn_type    in_cmn,
   input  v3alu_pkg::uword_type  in_sq,
   output v3alu_pkg::cmn_type    out_cmn
);
   localparam int QW  = v3alu_pkg::QW;
   localparam int PW  = v3alu_pkg::PW;
   localparam int NSQ = v3alu_pkg::NSQ;

   v3alu_pkg::cmn_type    cmn_q   [0:NSQ];
   v3alu_pkg::uword_type  rem_q   [0:NSQ];
   v3alu_pkg::uword_type  res_q   [0:NSQ];
   v3alu_pkg::uword_type  rem_in  [1:NSQ];
   v3alu_pkg::uword_type  res_in  [1:NSQ];
   v3alu_pkg::cmn_type    cmn_ff  [1:NSQ];
   v3alu_pkg::uword_type  rem_ff  [1:NSQ];
   v3alu_pkg::uword_type  res_ff  [1:NSQ];
   logic [QW:0]           root_lo;
   logic [QW:0]           root_r;
   v3alu_pkg::q_type      mag;
   v3alu_pkg::cmn_type    out_in;
   v3alu_pkg::cmn_type    out_ff;

   assign cmn_q[0] = in_cmn;
   assign rem_q[0] = in_sq;
   assign res_q[0] = '0;

   for (genvar k = 1; k <= NSQ; k++) begin : g_src
      assign cmn_q[k] = cmn_ff[k];
      assign rem_q[k] = rem_ff[k];
      assign res_q[k] = res_ff[k];
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_step
      localparam v3alu_pkg::uword_type BIT = v3alu_pkg::uword_type'(1) << (PW - 2 - 2 * k);
      v3alu_pkg::uword_type trial;
      logic                 take;
      assign trial      = res_q[k] + BIT;
      assign take       = rem_q[k] >= trial;
      assign rem_in[k+1] = take ? rem_q[k] - trial : rem_q[k];
      assign res_in[k+1] = take ? (res_q[k] >> 1) + BIT : res_q[k] >> 1;
   end

   always_comb begin
      root_lo = res_q[NSQ][QW:0];
      // remainder above the root means the true root is past the half point
      if (rem_q[NSQ] > res_q[NSQ]) begin
         root_r = root_lo + {{QW{1'b0}}, 1'b1};
      end else begin
         root_r = root_lo;
      end
      if (|root_r[QW:QW-1]) begin
         mag = v3alu_pkg::Q_MAX;
      end else begin
         mag = v3alu_pkg::q_type'(root_r[QW-1:0]);
      end
      out_in = cmn_q[NSQ];
      if (out_in.action == v3alu_pkg::OP_MAG || out_in.action == v3alu_pkg::OP_NORM) begin
         out_in.sc = mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSQ; k++) begin
            cmn_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         for (int k = 1; k <= NSQ; k++) begin
            cmn_ff[k] <= cmn_q[k-1];
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign out_cmn = out_ff;

endmodule

FILE: src/v3alu_div.sv
// pipelined four-lane restoring divider, one quotient bit per stage
// depends on v3alu_pkg; does vector divide and the normalize reciprocal
module v3alu_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  v3alu_pkg::cmn_type  in_cmn,
   output v3alu_pkg::cmn_type  out_cmn,
   output v3alu_pkg::q_type    out_recip
);
   localparam int QW    = v3alu_pkg::QW;
   localparam int PW    = v3alu_pkg::PW;
   localparam int LANES = v3alu_pkg::LANES;
   localparam int NDIV  = v3alu_pkg::NDIV;
   localparam int FB    = v3alu_pkg::FRAC_BITS;

   v3alu_pkg::lane_type   setup  [LANES];
   logic [QW-1:0]         au;
   logic [QW-1:0]         abs_a;
   logic [QW-1:0]         su;
   logic [QW-1:0]         abs_s;
   v3alu_pkg::uword_type  num;
   logic                  is_norm;

   v3alu_pkg::cmn_type    cmn_ff  [0:NDIV];
   v3alu_pkg::lane_type   lane_ff [0:NDIV][LANES];
   v3alu_pkg::lane_type   lane_in [1:NDIV][LANES];

   v3alu_pkg::q_type      qv [LANES];
   v3alu_pkg::cmn_type    out_in;
   v3alu_pkg::cmn_type    out_ff;
   v3alu_pkg::q_type      recip_ff;

   // setup: magnitudes, half-divisor bias for rounding, overflow test
   always_comb begin
      is_norm = in_cmn.action == v3alu_pkg::OP_NORM;
      su      = in_cmn.s;
      abs_s   = su[QW-1] ? {QW{1'b0}} - su : su;
      au      = '0;
      abs_a   = '0;
      num     = '0;
      for (int i = 0; i < LANES; i++) begin
         au    = in_cmn.a[i];
         abs_a = au[QW-1] ? {QW{1'b0}} - au : au;
         if (is_norm && i == 0) begin
            num           = v3alu_pkg::uword_type'(1) << (2 * FB);
            setup[i].d    = in_cmn.sc;
            setup[i].neg  = 1'b0;
         end else begin
            num           = v3alu_pkg::uword_type'(abs_a) << FB;
            setup[i].d    = abs_s;
            setup[i].neg  = au[QW-1] ^ su[QW-1];
         end
         setup[i].rem = num + v3alu_pkg::uword_type'(setup[i].d >> 1);
         setup[i].q   = '0;
         setup[i].ovf = setup[i].rem[PW-1:QW] >= setup[i].d;
      end
   end

   for (genvar k = 0; k < NDIV; k++) begin : g_step
      for (genvar i = 0; i < LANES; i++) begin : g_lane
         v3alu_pkg::uword_type dsh;
         logic                 take;
         assign dsh  = v3alu_pkg::uword_type'(lane_ff[k][i].d) << (QW - 1 - k);
         assign take = lane_ff[k][i].rem >= dsh;
         always_comb begin
            lane_in[k+1][i] = lane_ff[k][i];
            if (take) begin
               lane_in[k+1][i].rem         = lane_ff[k][i].rem - dsh;
               lane_in[k+1][i].q[QW-1-k]   = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (lane_ff[NDIV][i].neg) begin
            if (lane_ff[NDIV][i].ovf || (lane_ff[NDIV][i].q[QW-1] && |lane_ff[NDIV][i].q[QW-2:0]))
            begin
               qv[i] = v3alu_pkg::Q_MIN;
            end else begin
               qv[i] = {QW{1'b0}} - lane_ff[NDIV][i].q;
            end
         end else if (lane_ff[NDIV][i].ovf || lane_ff[NDIV][i].q[QW-1]) begin
            qv[i] = v3alu_pkg::Q_MAX;
         end else begin
            qv[i] = lane_ff[NDIV][i].q;
         end
      end
      out_in = cmn_ff[NDIV];
      if (out_in.action == v3alu_pkg::OP_DIVIDE) begin
         if (out_in.s == '0) begin
            out_in.dz = 1'b1;
         end else begin
            for (int i = 0; i < LANES; i++) begin
               out_in.r[i] = qv[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NDIV; k++) begin
            cmn_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         cmn_ff[0] <= in_cmn;
         for (int i = 0; i < LANES; i++) begin
            lane_ff[0][i] <= setup[i];
         end
         for (int k = 1; k <= NDIV; k++) begin
            cmn_ff[k] <= cmn_ff[k-1];
            for (int i = 0; i < LANES; i++) begin
               lane_ff[k][i] <= lane_in[k][i];
            end
         end
         out_ff   <= out_in;
         recip_ff <= qv[0];
      end
   end

   assign out_cmn   = out_ff;
   assign out_recip = recip_ff;

endmodule

FILE: src/v3alu_back.sv
// last two stages: normalize products, rounding, and the result register
// depends on v3alu_pkg
module v3alu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  v3alu_pkg::cmn_type  in_cmn,
   input  v3alu_pkg::q_type    in_recip,
   output logic                out_valid,
   output v3alu_pkg::rsp_type  out_data
);
   localparam int LANES = v3alu_pkg::LANES;

   v3alu_pkg::cmn_type   cmn_ff;
   v3alu_pkg::prod_type  prod_ff [LANES];
   v3alu_pkg::q_type     r [LANES];
   v3alu_pkg::rsp_type   data_in;
   v3alu_pkg::rsp_type   data_ff;
   logic                 valid_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         r[i] = cmn_ff.r[i];
         // zero magnitude leaves the vector at zero
         if (cmn_ff.action == v3alu_pkg::OP_NORM && cmn_ff.sc != '0) begin
            r[i] = v3alu_pkg::round_q(v3alu_pkg::wide_type'(prod_ff[i]));
         end
      end
      data_in.rx         = r[0];
      data_in.ry         = r[1];
      data_in.rz         = r[2];
      data_in.rw         = r[3];
      data_in.scalar_out = cmn_ff.sc;
      data_in.div_zero   = cmn_ff.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmn_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         cmn_ff <= in_cmn;
         for (int i = 0; i < LANES; i++) begin
            prod_ff[i] <= v3alu_pkg::prod_type'(in_cmn.a[i])
                        * v3alu_pkg::prod_type'(in_recip);
         end
         valid_ff <= cmn_ff.valid;
         data_ff  <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: src/vector3_alu.sv
// top level of the fixed-point vector arithmetic unit
// depends on v3alu_pkg, v3alu_if, v3alu_front, v3alu_sqrt, v3alu_div, v3alu_back
//
// Takes one request per clock while no result is held and returns one result per request,
// in order. All values are signed Q16.16 and every result saturates. The latency is set
// by the 32-stage square root and the 32-stage divider, each retiring one bit per stage;
// every opcode passes through both so results never reorder. When the result register
// holds a result that is not taken, the whole pipeline holds and req_if.ready drops in
// the same cycle.
module vector3_alu (
   input logic           clock,
   input logic           reset,
   v3alu_req_if.sink     req_if,
   v3alu_rsp_if.source   rsp_if
);
   logic                en;
   v3alu_pkg::cmn_type  front_cmn;
   v3alu_pkg::uword_type front_sq;
   v3alu_pkg::cmn_type  sqrt_cmn;
   v3alu_pkg::cmn_type  div_cmn;
   v3alu_pkg::q_type    div_recip;

   assign en           = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = en;

   v3alu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_if.valid),
      .in_data  (req_if.data),
      .out_cmn  (front_cmn),
      .out_sq   (front_sq)
   );

   v3alu_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_cmn  (front_cmn),
      .in_sq   (front_sq),
      .out_cmn (sqrt_cmn)
   );

   v3alu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_cmn    (sqrt_cmn),
      .out_cmn   (div_cmn),
      .out_recip (div_recip)
   );

   v3alu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_cmn    (div_cmn),
      .in_recip  (div_recip),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_if.data)
   );

endmodule

FILE: test/tb_vector3_alu.sv
`timescale 1ns / 1ps
// self-checking testbench for vector3_alu: directed corners, a random stream and back-pressure
// depends on v3alu_pkg and v3alu_if; results are predicted in place and checked in order
module tb_vector3_alu;

   typedef logic signed [79:0] acc_type;

   localparam int LATENCY     = 71;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 390;

   logic clock;
   logic reset;
   int   cycles;
   int   err_count;
   int   checked_count;
   int   hold_request;
   int   sent_count;
   int   op_counts [8];

   v3alu_pkg::rsp_type expected_results [$];

   v3alu_req_if req ();
   v3alu_rsp_if rsp ();

   vector3_alu dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------- fixed-point arithmetic ----------------

   function automatic v3alu_pkg::q_type clamp_q(acc_type v);
      if (v > acc_type'(v3alu_pkg::Q_MAX)) begin
         return v3alu_pkg::Q_MAX;
      end else if (v < acc_type'(v3alu_pkg::Q_MIN)) begin
         return v3alu_pkg::Q_MIN;
      end
      return v3alu_pkg::q_type'(v);
   endfunction

   // round to nearest with ties toward plus infinity
   function automatic v3alu_pkg::q_type round_fixed(acc_type v);
      acc_type t;
      t = (v + (acc_type'(1) <<< (v3alu_pkg::FRAC_BITS - 1))) >>> v3alu_pkg::FRAC_BITS;
      return clamp_q(t);
   endfunction

   // round to nearest with ties away from zero
   function automatic v3alu_pkg::q_type divide_fixed(acc_type num, acc_type den);
      logic    neg;
      acc_type n;
      acc_type d;
      acc_type q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n + d / 2) / d;
      if (q > (acc_type'(1) <<< 40)) begin
         q = acc_type'(1) <<< 40;
      end
      return clamp_q(neg ? -q : q);
   endfunction

   function automatic v3alu_pkg::q_type length_fixed(v3alu_pkg::q_type x, v3alu_pkg::q_type y,
                                                     v3alu_pkg::q_type z);
      acc_type s;
      acc_type root;
      acc_type cand;
      s = acc_type'(x) * acc_type'(x) + acc_type'(y) * acc_type'(y)
        + acc_type'(z) * acc_type'(z);
      root = 0;
      for (int i = 33; i >= 0; i--) begin
         cand = root | (acc_type'(1) <<< i);
         if (cand * cand <= s) begin
            root = cand;
         end
      end
      if (s - root * root > root) begin
         root = root + 1;
      end
      return clamp_q(root);
   endfunction

   function automatic v3alu_pkg::rsp_type alu_result(v3alu_pkg::req_type r);
      v3alu_pkg::rsp_type res;
      v3alu_pkg::q_type   a [4];
      v3alu_pkg::q_type   out [4];
      v3alu_pkg::q_type   len;
      v3alu_pkg::q_type   recip;
      a = '{r.ax, r.ay, r.az, r.aw};
      out = '{default: '0};
      res = '0;
      case (r.action)
         v3alu_pkg::OP_ADD: begin
            out = '{clamp_q(acc_type'(r.ax) + r.bx), clamp_q(acc_type'(r.ay) + r.by),
                    clamp_q(acc_type'(r.az) + r.bz), clamp_q(acc_type'(r.aw) + r.bw)};
         end
         v3alu_pkg::OP_SUB: begin
            out = '{clamp_q(acc_type'(r.ax) - r.bx), clamp_q(acc_type'(r.ay) - r.by),
                    clamp_q(acc_type'(r.az) - r.bz), clamp_q(acc_type'(r.aw) - r.bw)};
         end
         v3alu_pkg::OP_SCALE: begin
            foreach (a[i]) out[i] = round_fixed(acc_type'(a[i]) * acc_type'(r.scalar));
         end
         v3alu_pkg::OP_DIVIDE: begin
            if (r.scalar == 0) begin
               res.div_zero = 1'b1;
            end else begin
               foreach (a[i]) out[i] = divide_fixed(acc_type'(a[i]) <<< v3alu_pkg::FRAC_BITS,
                                                     acc_type'(r.scalar));
            end
         end
         v3alu_pkg::OP_DOT: begin
            res.scalar_out = round_fixed(acc_type'(r.ax) * r.bx + acc_type'(r.ay) * r.by
                                       + acc_type'(r.az) * r.bz);
         end
         v3alu_pkg::OP_CROSS: begin
            out[0] = round_fixed(acc_type'(r.ay) * r.bz - acc_type'(r.by) * r.az);
            out[1] = round_fixed(acc_type'(r.az) * r.bx - acc_type'(r.bz) * r.ax);
            out[2] = round_fixed(acc_type'(r.ax) * r.by - acc_type'(r.bx) * r.ay);
            out[3] = v3alu_pkg::ONE_Q;
         end
         v3alu_pkg::OP_MAG: begin
            res.scalar_out = length_fixed(r.ax, r.ay, r.az);
         end
         default: begin
            len = length_fixed(r.ax, r.ay, r.az);
            res.scalar_out = len;
            if (len > 0) begin
               recip = divide_fixed(acc_type'(1) <<< (2 * v3alu_pkg::FRAC_BITS),
                                    acc_type'(len));
               foreach (a[i]) out[i] = round_fixed(acc_type'(a[i]) * acc_type'(recip));
            end
         end
      endcase
      res.rx = out[0];
      res.ry = out[1];
      res.rz = out[2];
      res.rw = out[3];
      return res;
   endfunction

   // ---------------- checking ----------------

   task automatic report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      err_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s got %h expected %h (result %0d)", name, got, want,
                          checked_count));
      end
   endtask

   int stall_left;

   // receiver: stall pattern rotates through four modes, plus long holds on request
   always @(posedge clock) begin
      v3alu_pkg::rsp_type want;
      v3alu_pkg::rsp_type got;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (expected_results.size() == 0) begin
               report("result with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("rx", got.rx, want.rx);
               check_field("ry", got.ry, want.ry);
               check_field("rz", got.rz, want.rz);
               check_field("rw", got.rw, want.rw);
               check_field("scalar_out", got.scalar_out, want.scalar_out);
               check_field("div_zero", got.div_zero, want.div_zero);
            end
            checked_count++;
         end
         if (hold_request > 0) begin
            stall_left <= hold_request;
            hold_request = 0;
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            case ((cycles / 64) % 4)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= ($urandom_range(0, 1) == 1);
               2: rsp.ready <= (cycles % 3 == 0);
               default: rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------- stimulus ----------------

   int burst_left;

   // holds valid until accepted; in bursty mode gaps may be inserted between bursts
   task automatic send(v3alu_pkg::req_type item, bit bursty);
      int gap;
      req.valid <= 1'b1;
      req.data  <= item;
      do @(posedge clock); while (!req.ready);
      expected_results.push_back(alu_result(item));
      op_counts[item.action]++;
      sent_count++;
      if (bursty) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic idle_input();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic v3alu_pkg::q_type rand_q();
      case ($urandom_range(0, 5))
         0, 1: return v3alu_pkg::q_type'($urandom);
         2:    return v3alu_pkg::q_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         3:    return v3alu_pkg::q_type'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
         4: begin
            case ($urandom_range(0, 3))
               0: return v3alu_pkg::Q_MAX;
               1: return v3alu_pkg::Q_MIN;
               2: return v3alu_pkg::ONE_Q;
               default: return -v3alu_pkg::ONE_Q;
            endcase
         end
         default: return v3alu_pkg::q_type'(int'($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   function automatic v3alu_pkg::req_type rand_req();
      v3alu_pkg::req_type r;
      r.action = v3alu_pkg::op_type'($urandom_range(0, 7));
      r.ax = rand_q(); r.ay = rand_q(); r.az = rand_q(); r.aw = rand_q();
      r.bx = rand_q(); r.by = rand_q(); r.bz = rand_q(); r.bw = rand_q();
      r.scalar = ($urandom_range(0, 9) == 0) ? v3alu_pkg::q_type'(0) : rand_q();
      return r;
   endfunction

   function automatic v3alu_pkg::req_type make_req(v3alu_pkg::op_type op, v3alu_pkg::q_type a,
                                                   v3alu_pkg::q_type b, v3alu_pkg::q_type s);
      v3alu_pkg::req_type r;
      r.action = op;
      r.ax = a; r.ay = a; r.az = a; r.aw = a;
      r.bx = b; r.by = b; r.bz = b; r.bw = b;
      r.scalar = s;
      return r;
   endfunction

   task automatic wait_drained();
      wait (expected_results.size() == 0);
      @(posedge clock);
   endtask

   task automatic test_directed();
      v3alu_pkg::req_type r;
      send(make_req(v3alu_pkg::OP_ADD, v3alu_pkg::Q_MAX, v3alu_pkg::Q_MAX, 0), 0); // positive sat
      send(make_req(v3alu_pkg::OP_ADD, v3alu_pkg::Q_MIN, v3alu_pkg::Q_MIN, 0), 0); // negative sat
      send(make_req(v3alu_pkg::OP_SUB, v3alu_pkg::Q_MIN, v3alu_pkg::Q_MAX, 0), 0);
      send(make_req(v3alu_pkg::OP_SUB, v3alu_pkg::Q_MAX, v3alu_pkg::Q_MIN, 0), 0);
      send(make_req(v3alu_pkg::OP_SCALE, v3alu_pkg::Q_MAX, 0, v3alu_pkg::Q_MAX), 0);
      send(make_req(v3alu_pkg::OP_SCALE, v3alu_pkg::Q_MIN, 0, v3alu_pkg::Q_MAX), 0);
      send(make_req(v3alu_pkg::OP_SCALE, 32'sh0001_8000, 0, 32'sh0000_0001), 0); // rounding tie
      send(make_req(v3alu_pkg::OP_DIVIDE, v3alu_pkg::ONE_Q, 0, 0), 0);         // zero divisor
      send(make_req(v3alu_pkg::OP_DIVIDE, v3alu_pkg::Q_MAX, 0, 32'sh0000_0001), 0);
      send(make_req(v3alu_pkg::OP_DIVIDE, v3alu_pkg::Q_MIN, 0, -32'sh0000_0001), 0);
      send(make_req(v3alu_pkg::OP_DIVIDE, v3alu_pkg::ONE_Q, 0, 32'sh0003_0000), 0);
      send(make_req(v3alu_pkg::OP_DIVIDE, -v3alu_pkg::ONE_Q, 0, 32'sh0002_0000), 0);
      send(make_req(v3alu_pkg::OP_DOT, v3alu_pkg::Q_MAX, v3alu_pkg::Q_MAX, 0), 0);
      send(make_req(v3alu_pkg::OP_DOT, v3alu_pkg::Q_MIN, v3alu_pkg::Q_MAX, 0), 0);
      r = make_req(v3alu_pkg::OP_CROSS, v3alu_pkg::ONE_Q, 0, 0);
      r.ay = 0; r.az = 0; r.bx = 0; r.by = v3alu_pkg::ONE_Q; r.bz = 0;
      send(r, 0);
      r.ax = v3alu_pkg::Q_MIN; r.ay = v3alu_pkg::Q_MAX; r.az = v3alu_pkg::Q_MIN;
      r.bx = v3alu_pkg::Q_MAX; r.by = v3alu_pkg::Q_MIN; r.bz = v3alu_pkg::Q_MAX;
      send(r, 0);
      send(make_req(v3alu_pkg::OP_MAG, 0, 0, 0), 0);
      send(make_req(v3alu_pkg::OP_MAG, v3alu_pkg::Q_MIN, 0, 0), 0);
      send(make_req(v3alu_pkg::OP_MAG, 32'sh0003_0000, 0, 0), 0);
      send(make_req(v3alu_pkg::OP_NORM, 0, 0, 0), 0);               // zero length
      send(make_req(v3alu_pkg::OP_NORM, 32'sh0000_0001, 0, 0), 0);  // tiny length
      send(make_req(v3alu_pkg::OP_NORM, v3alu_pkg::Q_MAX, 0, 0), 0); // saturated length
      send(make_req(v3alu_pkg::OP_NORM, 32'sh0002_0000, 0, 0), 0);
      idle_input();
      wait_drained();
   endtask

   task automatic test_random_stream();
      for (int i = 0; i < RANDOM_REQS; i++) begin
         send(rand_req(), 1);
      end
      idle_input();
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      for (int i = 0; i < 120; i++) begin
         send(rand_req(), 0);
      end
      idle_input();
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 10; i++) begin
         send(rand_req(), 1);
      end
      idle_input();
      wait_drained();
      for (int i = 0; i < 10; i++) begin
         send(rand_req(), 0);
      end
      idle_input();
   endtask

   initial begin
      cycles = 0;
      err_count = 0;
      checked_count = 0;
      sent_count = 0;
      hold_request = 0;
      burst_left = 0;
      foreach (op_counts[i]) op_counts[i] = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_stream();
      test_backpressure();
      test_pause_until_drained();

      wait (expected_results.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("%0d requests sent, %0d results checked", sent_count, checked_count);
      $display("per opcode: add %0d sub %0d scale %0d div %0d dot %0d cross %0d mag %0d norm %0d",
               op_counts[0], op_counts[1], op_counts[2], op_counts[3], op_counts[4],
               op_counts[5], op_counts[6], op_counts[7]);
      if (err_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/v3alu_pkg.sv
src/v3alu_if.sv
src/v3alu_front.sv
src/v3alu_sqrt.sv
src/v3alu_div.sv
src/v3alu_back.sv
src/vector3_alu.sv
test/tb_vector3_alu.sv
